// File: hdl/irb_pkg.sv
// Shared constants, register codes and stage records for the bilinear rotation block.
package irb_pkg;

    // Default store geometry
    localparam int DEF_MAX_WIDTH    = 128;
    localparam int DEF_MAX_HEIGHT   = 128;
    localparam int DEF_MAX_CHANNELS = 4;

    // Item actions
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Configuration register indexes
    localparam int              CFG_IDX_W      = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_COS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd3;

    // Register reset values
    localparam logic [15:0] COS_RST  = 16'h4000;
    localparam logic [15:0] SIN_RST  = 16'h0000;
    localparam logic [7:0]  SIZE_RST = 8'd128;

    // Fixed point: weights with 14 fraction bits, products with 28, round to nearest
    localparam logic [14:0] FRAC_ONE   = 15'd16384;
    localparam int          ACC_W      = 45;
    localparam logic [ACC_W-1:0] ROUND_BIAS = 45'h000008000000;

    // Index of the last neighbour tap of a query
    localparam logic [1:0] TAP_LAST = 2'd3;

    // Item after the coordinate stage
    typedef struct packed {
        logic        action;
        logic [1:0]  channel;
        logic [6:0]  row;
        logic [6:0]  col;
        logic [15:0] sample;
        logic        ok;      // load: inside store; query: inside size in use
        logic [13:0] x0;      // floor of source x, two's complement
        logic [13:0] y0;      // floor of source y, two's complement
        logic [13:0] fx;
        logic [13:0] fy;
    } coord_t;

    // One neighbour read handed to the blend pipeline
    typedef struct packed {
        logic        valid;
        logic        first;
        logic        last;
        logic        inb;     // query and neighbour inside size; else it reads as zero
        logic [28:0] weight;
    } tap_t;

endpackage

// File: hdl/image_rotate_bilinear.sv
// Top level: configuration registers, tap sequencer and store addressing.
// A query's result strobe (done) follows its last neighbour read through the store read,
// tap, product and done registers. A query holds the single memory port for its four neighbour
// reads, a load for one write; items enter back to back unless busy rises while the port is held.
// Reset: rst_n clears control state and sets cos=1.0, sin=0, size 128x128; the store
// keeps no reset value. Results cannot be stalled; done marks each one for one cycle.
module image_rotate_bilinear
    import irb_pkg::*;
#(
    parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 action,
    input  logic [1:0]           channel,
    input  logic [6:0]           row,
    input  logic [6:0]           col,
    input  logic [15:0]          sample_in,
    output logic                 done,
    output logic [15:0]          sample_out,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);

    localparam int DEPTH = MAX_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] PLANE_STEP = AW'(MAX_HEIGHT * MAX_WIDTH);
    localparam logic [AW-1:0] ROW_STEP   = AW'(MAX_WIDTH);

    logic signed [15:0] cos_reg;
    logic signed [15:0] sin_reg;
    logic [7:0]         width_reg;
    logic [7:0]         height_reg;
    logic [7:0]         eff_w;
    logic [7:0]         eff_h;

    logic               accept;
    logic               s1_valid;
    coord_t             coord;

    logic               iss_valid_reg;
    logic               iss_valid_next;
    logic [1:0]         iss_cnt_reg;
    logic [1:0]         iss_cnt_next;
    coord_t             iss_reg;
    logic               iss_done;
    logic               iss_take;
    logic               iss_load;

    logic               dx;
    logic               dy;
    logic signed [14:0] nx;
    logic signed [14:0] ny;
    logic               inb;
    logic [14:0]        wx;
    logic [14:0]        wy;
    tap_t               tap;

    logic               mem_we;
    logic [1:0]         a_ch;
    logic [7:0]         a_y;
    logic [7:0]         a_x;
    logic [AW-1:0]      mem_addr;
    logic [15:0]        mem_rdata;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_reg    <= COS_RST;
            sin_reg    <= SIN_RST;
            width_reg  <= SIZE_RST;
            height_reg <= SIZE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_COS:    cos_reg    <= cfg_data;
                CFG_SIN:    sin_reg    <= cfg_data;
                CFG_WIDTH:  width_reg  <= cfg_data[7:0];
                CFG_HEIGHT: height_reg <= cfg_data[7:0];
                default:    ;
            endcase
        end
    end

    // Size in use, limited to the store
    assign eff_w = (32'(width_reg) > MAX_WIDTH) ? 8'(MAX_WIDTH) : width_reg;
    assign eff_h = (32'(height_reg) > MAX_HEIGHT) ? 8'(MAX_HEIGHT) : height_reg;

    // Handshake: the coordinate stage stalls while the port is held
    assign iss_done = iss_valid_reg && (iss_reg.action == ACT_LOAD || iss_cnt_reg == TAP_LAST);
    assign iss_take = !iss_valid_reg || iss_done;
    assign busy     = s1_valid && !iss_take;
    assign accept   = start && !busy;
    assign iss_load = s1_valid && iss_take;

    irb_coord #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_coord (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .action    (action),
        .channel   (channel),
        .row       (row),
        .col       (col),
        .sample_in (sample_in),
        .cos_q14   (cos_reg),
        .sin_q14   (sin_reg),
        .eff_w     (eff_w),
        .eff_h     (eff_h),
        .out_take  (iss_take),
        .out_valid (s1_valid),
        .coord     (coord)
    );

    // Tap sequencer
    always_comb
    begin
        iss_valid_next = iss_valid_reg;
        iss_cnt_next   = iss_cnt_reg;
        if (iss_load)
        begin
            iss_valid_next = 1'b1;
            iss_cnt_next   = 2'd0;
        end
        else if (iss_done)
        begin
            iss_valid_next = 1'b0;
            iss_cnt_next   = 2'd0;
        end
        else if (iss_valid_reg)
        begin
            iss_cnt_next = iss_cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_valid_reg <= 1'b0;
            iss_cnt_reg   <= 2'd0;
        end
        else
        begin
            iss_valid_reg <= iss_valid_next;
            iss_cnt_reg   <= iss_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (iss_load)
        begin
            iss_reg <= coord;
        end
    end

    // Neighbour of the current tap and its weight
    assign dx  = iss_cnt_reg[0];
    assign dy  = iss_cnt_reg[1];
    assign nx  = $signed({iss_reg.x0[13], iss_reg.x0}) + $signed({14'b0, dx});
    assign ny  = $signed({iss_reg.y0[13], iss_reg.y0}) + $signed({14'b0, dy});
    assign inb = iss_reg.ok && !nx[14] && !ny[14]
                 && (nx[13:0] < {6'b0, eff_w}) && (ny[13:0] < {6'b0, eff_h});
    assign wx  = dx ? {1'b0, iss_reg.fx} : FRAC_ONE - {1'b0, iss_reg.fx};
    assign wy  = dy ? {1'b0, iss_reg.fy} : FRAC_ONE - {1'b0, iss_reg.fy};

    always_comb
    begin
        tap.valid  = iss_valid_reg && iss_reg.action == ACT_QUERY;
        tap.first  = iss_cnt_reg == 2'd0;
        tap.last   = iss_cnt_reg == TAP_LAST;
        tap.inb    = inb;
        tap.weight = 29'(wx) * 29'(wy);
    end

    // Store address: channel plane, row, column
    assign mem_we = iss_valid_reg && iss_reg.action == ACT_LOAD && iss_reg.ok;
    assign a_ch   = iss_reg.channel;
    assign a_y    = (iss_reg.action == ACT_LOAD) ? {1'b0, iss_reg.row} : ny[7:0];
    assign a_x    = (iss_reg.action == ACT_LOAD) ? {1'b0, iss_reg.col} : nx[7:0];
    assign mem_addr = AW'(a_ch) * PLANE_STEP + AW'(a_y) * ROW_STEP + AW'(a_x);

    irb_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (iss_reg.sample),
        .rdata (mem_rdata)
    );

    irb_blend u_blend (
        .clk        (clk),
        .rst_n      (rst_n),
        .tap        (tap),
        .rdata      (mem_rdata),
        .done       (done),
        .sample_out (sample_out)
    );

    // A stall only happens while the port is held by an item
    a_busy_held: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (iss_valid_reg && !iss_done))
        else $error("busy without an item holding the port");

    // A load holds the sequencer only while its tap count is zero
    a_load_single: assert property (@(posedge clk) disable iff (!rst_n)
        (iss_valid_reg && iss_reg.action == ACT_LOAD) |-> iss_cnt_reg == 2'd0)
        else $error("load held the port for more than one cycle");

    // Tap count moves only with an item in the sequencer
    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !iss_valid_reg |-> iss_cnt_reg == 2'd0)
        else $error("tap count set while sequencer empty");

    // A query's taps run in consecutive cycles
    a_tap_step: assert property (@(posedge clk) disable iff (!rst_n)
        (tap.valid && !tap.last) |=> (tap.valid && iss_cnt_reg == $past(iss_cnt_reg) + 2'd1))
        else $error("query tap sequence broken");

endmodule

// File: hdl/irb_coord.sv
// Coordinate stage: rotation products, range checks and source floor/fraction.
module irb_coord
    import irb_pkg::*;
#(
    parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               action,
    input  logic [1:0]         channel,
    input  logic [6:0]         row,
    input  logic [6:0]         col,
    input  logic [15:0]        sample_in,
    input  logic signed [15:0] cos_q14,
    input  logic signed [15:0] sin_q14,
    input  logic [7:0]         eff_w,
    input  logic [7:0]         eff_h,
    input  logic               out_take,
    output logic               out_valid,
    output coord_t             coord
);

    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic               act_reg;
    logic [1:0]         ch_reg;
    logic [6:0]         row_reg;
    logic [6:0]         col_reg;
    logic [15:0]        smp_reg;
    logic               ok_reg;
    logic signed [25:0] p_cx_reg;
    logic signed [25:0] p_sy_reg;
    logic signed [25:0] p_cy_reg;
    logic signed [25:0] p_sx_reg;

    logic signed [9:0]  dx2;
    logic signed [9:0]  dy2;
    logic               ok_in;
    logic signed [28:0] w_sh;
    logic signed [28:0] h_sh;
    logic signed [28:0] sx;
    logic signed [28:0] sy;

    // Doubled offsets from the center
    assign dx2 = $signed({2'b00, col, 1'b0}) - $signed({2'b00, eff_w});
    assign dy2 = $signed({2'b00, row, 1'b0}) - $signed({2'b00, eff_h});

    // Load: inside the store; query: inside the size in use
    always_comb
    begin
        if (action == ACT_LOAD)
        begin
            ok_in = (32'(channel) < MAX_CHANNELS) && (32'(row) < MAX_HEIGHT)
                    && (32'(col) < MAX_WIDTH);
        end
        else
        begin
            ok_in = (32'(channel) < MAX_CHANNELS) && ({1'b0, row} < eff_h)
                    && ({1'b0, col} < eff_w);
        end
    end

    // Valid bit of the stage
    assign s1_valid_next = in_valid | (s1_valid_reg & ~out_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Payload and the four rotation products
    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            act_reg  <= action;
            ch_reg   <= channel;
            row_reg  <= row;
            col_reg  <= col;
            smp_reg  <= sample_in;
            ok_reg   <= ok_in;
            p_cx_reg <= 26'(cos_q14) * 26'(dx2);
            p_sy_reg <= 26'(sin_q14) * 26'(dy2);
            p_cy_reg <= 26'(cos_q14) * 26'(dy2);
            p_sx_reg <= 26'(sin_q14) * 26'(dx2);
        end
    end

    // Source coordinates in units of 2^-15
    assign w_sh = $signed({7'b0, eff_w, 14'b0});
    assign h_sh = $signed({7'b0, eff_h, 14'b0});
    assign sx   = 29'(p_cx_reg) + 29'(p_sy_reg) + w_sh;
    assign sy   = 29'(p_cy_reg) - 29'(p_sx_reg) + h_sh;

    always_comb
    begin
        coord.action  = act_reg;
        coord.channel = ch_reg;
        coord.row     = row_reg;
        coord.col     = col_reg;
        coord.sample  = smp_reg;
        coord.ok      = ok_reg;
        coord.x0      = sx[28:15];
        coord.y0      = sy[28:15];
        coord.fx      = sx[14:1];
        coord.fy      = sy[14:1];
    end

    assign out_valid = s1_valid_reg;

endmodule

// File: hdl/irb_store.sv
// Single-port image store with registered read data.
module irb_store
    import irb_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_CHANNELS * DEF_MAX_HEIGHT * DEF_MAX_WIDTH,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [15:0]   wdata,
    output logic [15:0]   rdata
);

    logic [15:0] mem [DEPTH];
    logic [15:0] rdata_reg;

    // One access per cycle: write or read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/irb_blend.sv
// Blend pipeline: weight times sample, accumulate four taps, round and clamp.
module irb_blend
    import irb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  tap_t        tap,
    input  logic [15:0] rdata,
    output logic        done,
    output logic [15:0] sample_out
);

    tap_t             tap_reg;
    logic             pvalid_reg;
    logic             pfirst_reg;
    logic             plast_reg;
    logic [ACC_W-1:0] prod_reg;
    logic [ACC_W-1:0] acc_reg;
    logic             done_reg;
    logic [15:0]      out_reg;

    logic [15:0]      smp;
    logic [ACC_W-1:0] acc_sum;
    logic [15:0]      res;

    // Tap info lines up with the memory read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg <= '0;
        end
        else
        begin
            tap_reg <= tap;
        end
    end

    // Neighbours outside the size read as zero
    assign smp = tap_reg.inb ? rdata : 16'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pvalid_reg <= 1'b0;
        end
        else
        begin
            pvalid_reg <= tap_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        pfirst_reg <= tap_reg.first;
        plast_reg  <= tap_reg.last;
        prod_reg   <= ACC_W'(tap_reg.weight) * ACC_W'(smp);
    end

    // Accumulate; the first tap starts from the rounding bias
    assign acc_sum = (pfirst_reg ? ROUND_BIAS : acc_reg) + prod_reg;
    assign res     = acc_sum[ACC_W-1:44] != 1'b0 ? 16'hFFFF : acc_sum[43:28];

    always_ff @(posedge clk)
    begin
        if (pvalid_reg)
        begin
            acc_reg <= acc_sum;
        end
        if (pvalid_reg && plast_reg)
        begin
            out_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= pvalid_reg & plast_reg;
        end
    end

    assign done       = done_reg;
    assign sample_out = out_reg;

    // Result strobe only follows the last tap of a query
    a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(tap_reg.valid && tap_reg.last, 2))
        else $error("result strobe without a last tap");

    // A first tap is never issued right after a non-last tap of a query
    a_taps_complete: assert property (@(posedge clk) disable iff (!rst_n)
        (tap_reg.valid && !tap_reg.last) |=> (tap_reg.valid && !tap_reg.first))
        else $error("query taps interrupted");

endmodule
